### rtl/lob_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lob_pkg
// Shared types and constants of the top-five order book block.
// -----------------------------------------------------------------------------
package lob_pkg;

    localparam int BOOK_DEPTH_DEF   = 256;
    localparam int LEVELS_SHOWN_DEF = 5;

    localparam logic [31:0] PRICE_MARKET_SELL = 32'hFFFF_FFFF;
    localparam logic [31:0] PRICE_MARKET_BUY  = 32'h0000_0000;
    localparam logic [31:0] VOLUME_SAT        = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_TRADE  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_OVERDRAWN = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SCAN_CLEAR  = 2'd0,
        SCAN_LOOKUP = 2'd1,
        SCAN_LEVELS = 2'd2,
        SCAN_IDLE   = 2'd3
    } t_scan_mode;

    typedef struct packed {
        logic [1:0]  operation;
        logic        side;
        logic        market;
        logic [31:0] order_id;
        logic [31:0] ask_id;
        logic [31:0] bid_id;
        logic [31:0] price;
        logic [23:0] volume;
    } t_in_item;

    typedef struct packed {
        logic        book_side;
        logic [2:0]  level;
        logic        level_valid;
        logic [31:0] level_price;
        logic [31:0] level_volume;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic        side;
        logic [31:0] id;
        logic [31:0] price;
        logic [23:0] volume;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic       accept_en;
        logic       run;
        t_scan_mode mode;
        logic       wr_first;
        logic       wr_second;
        logic       emit_start;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_xfer;
        logic scan_done;
        logic emit_done;
    } t_sts;

endpackage
`default_nettype wire

### rtl/lob_in_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lob_in_if
// Input channel of the order book: one item per transfer.
// -----------------------------------------------------------------------------
interface lob_in_if;
    logic              valid;
    logic              ready;
    lob_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/lob_out_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lob_out_if
// Result channel of the order book: one price level per transfer.
// -----------------------------------------------------------------------------
interface lob_out_if;
    logic               valid;
    logic               ready;
    lob_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/lob_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lob_ctrl
// Sequencer: clear pass, lookup scan, table writes, level scan, result drain.
// -----------------------------------------------------------------------------
module lob_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lob_pkg::t_sts i_sts,
    output lob_pkg::t_cmd o_cmd
);
    import lob_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_LOOKUP = 7'b0000100,
        S_WR0    = 7'b0001000,
        S_WR1    = 7'b0010000,
        S_LEVELS = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mode = SCAN_IDLE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.run  = 1'b1;
                o_cmd.mode = SCAN_CLEAR;
                if (i_sts.scan_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.accept_en = 1'b1;
                if (i_sts.in_xfer) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.run  = 1'b1;
                o_cmd.mode = SCAN_LOOKUP;
                if (i_sts.scan_done) n_state = S_WR0;
            end
            S_WR0: begin
                o_cmd.wr_first = 1'b1;
                n_state = S_WR1;
            end
            S_WR1: begin
                o_cmd.wr_second = 1'b1;
                n_state = S_LEVELS;
            end
            S_LEVELS: begin
                o_cmd.run  = 1'b1;
                o_cmd.mode = SCAN_LEVELS;
                if (i_sts.scan_done) begin
                    o_cmd.emit_start = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.emit_done) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    a_xfer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.in_xfer |-> r_state == S_IDLE)
        else $error("input transfer outside idle");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_sts.emit_done) |=> r_state == S_EMIT)
        else $error("left drain before last transfer");

endmodule
`default_nettype wire

### rtl/lob_datapath.sv
`default_nettype none
// -----------------------------------------------------------------------------
// lob_datapath
// Order table memory, id lookup, update logic, top-N level lists and
// result register.
// -----------------------------------------------------------------------------
module lob_datapath #(
    parameter int BOOK_DEPTH   = lob_pkg::BOOK_DEPTH_DEF,
    parameter int LEVELS_SHOWN = lob_pkg::LEVELS_SHOWN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lob_in_if.sink        i_in,
    lob_out_if.source     o_out,
    input  lob_pkg::t_cmd i_cmd,
    output lob_pkg::t_sts o_sts
);
    import lob_pkg::*;

    localparam int AW = $clog2(BOOK_DEPTH);
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int LW = (LEVELS_SHOWN > 1) ? $clog2(LEVELS_SHOWN) : 1;
    localparam logic [CW-1:0] CNT_END  = CW'(BOOK_DEPTH);
    localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS_SHOWN - 1);

    // ---------------- item capture ----------------
    t_in_item r_item;
    logic     w_in_xfer;

    assign i_in.ready = i_cmd.accept_en;
    assign w_in_xfer  = i_in.valid && i_cmd.accept_en;

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) r_item <= i_in.payload;
    end

    // ---------------- scan counter and memory ----------------
    logic [CW-1:0] r_cnt;
    logic          r_rv;
    t_entry        r_rdata;
    t_entry        r_mem [BOOK_DEPTH];
    logic          w_en;
    logic [AW-1:0] w_addr;
    t_entry        w_data;
    logic          w_read_mode;

    assign w_read_mode = i_cmd.mode == SCAN_LOOKUP || i_cmd.mode == SCAN_LEVELS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rv  <= 1'b0;
        end else begin
            if (!i_cmd.run)            r_cnt <= '0;
            else if (r_cnt != CNT_END) r_cnt <= r_cnt + 1'b1;
            r_rv <= i_cmd.run && w_read_mode && r_cnt != CNT_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_mem[w_addr] <= w_data;
        r_rdata <= r_mem[r_cnt[AW-1:0]];
    end

    assign o_sts.scan_done = i_cmd.run && r_cnt == CNT_END && !r_rv;
    assign o_sts.in_xfer   = w_in_xfer;

    // ---------------- lookup ----------------
    logic          r_free_found, r_a_found, r_b_found;
    logic [AW-1:0] r_free_idx, r_a_idx, r_b_idx;
    t_entry        r_a_ent, r_b_ent;
    logic [AW-1:0] r_ridx;

    always_ff @(posedge i_clk) begin
        r_ridx <= r_cnt[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_in_xfer) begin
            r_free_found <= 1'b0;
            r_a_found    <= 1'b0;
            r_b_found    <= 1'b0;
        end else if (r_rv && i_cmd.mode == SCAN_LOOKUP) begin
            if (!r_rdata.valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_ridx;
            end
            if (r_rdata.valid && r_rdata.side && r_rdata.id == r_item.ask_id
                    && !r_a_found) begin
                r_a_found <= 1'b1;
                r_a_idx   <= r_ridx;
                r_a_ent   <= r_rdata;
            end
            if (r_rdata.valid && !r_rdata.side && r_rdata.id == r_item.bid_id
                    && !r_b_found) begin
                r_b_found <= 1'b1;
                r_b_idx   <= r_ridx;
                r_b_ent   <= r_rdata;
            end
        end
    end

    // ---------------- status and writes ----------------
    t_status w_status;
    t_status r_status;
    logic    w_use_a;
    logic    w_a_over, w_b_over;
    t_entry  w_a_new, w_b_new, w_add_ent;

    assign w_use_a  = r_item.ask_id != 32'd0;
    assign w_a_over = r_item.volume > r_a_ent.volume;
    assign w_b_over = r_item.volume > r_b_ent.volume;

    always_comb begin
        case (r_item.operation)
            OP_ADD:   w_status = r_free_found ? ST_OK : ST_FULL;
            OP_TRADE: begin
                if (!r_a_found)     w_status = ST_UNKNOWN;
                else if (w_a_over)  w_status = ST_OVERDRAWN;
                else if (!r_b_found) w_status = ST_UNKNOWN;
                else if (w_b_over)  w_status = ST_OVERDRAWN;
                else                w_status = ST_OK;
            end
            OP_CANCEL: begin
                if (w_use_a) begin
                    if (!r_a_found)    w_status = ST_UNKNOWN;
                    else if (w_a_over) w_status = ST_OVERDRAWN;
                    else               w_status = ST_OK;
                end else begin
                    if (!r_b_found)    w_status = ST_UNKNOWN;
                    else if (w_b_over) w_status = ST_OVERDRAWN;
                    else               w_status = ST_OK;
                end
            end
            default:  w_status = ST_OK;
        endcase
    end

    always_comb begin
        w_a_new        = r_a_ent;
        w_a_new.volume = r_a_ent.volume - r_item.volume;
        w_a_new.valid  = w_a_new.volume != 24'd0;
        w_b_new        = r_b_ent;
        w_b_new.volume = r_b_ent.volume - r_item.volume;
        w_b_new.valid  = w_b_new.volume != 24'd0;
        w_add_ent.valid  = 1'b1;
        w_add_ent.side   = r_item.side;
        w_add_ent.id     = r_item.order_id;
        w_add_ent.volume = r_item.volume;
        if (r_item.market)
            w_add_ent.price = r_item.side ? PRICE_MARKET_SELL : PRICE_MARKET_BUY;
        else
            w_add_ent.price = r_item.price;
    end

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_cnt[AW-1:0];
        w_data = '0;
        if (i_cmd.run && i_cmd.mode == SCAN_CLEAR) begin
            w_en = r_cnt != CNT_END;
        end else if (i_cmd.wr_first && r_status == ST_OK) begin
            case (r_item.operation)
                OP_ADD: begin
                    w_en = 1'b1; w_addr = r_free_idx; w_data = w_add_ent;
                end
                OP_TRADE: begin
                    w_en = 1'b1; w_addr = r_a_idx; w_data = w_a_new;
                end
                OP_CANCEL: begin
                    w_en   = 1'b1;
                    w_addr = w_use_a ? r_a_idx : r_b_idx;
                    w_data = w_use_a ? w_a_new : w_b_new;
                end
                default: w_en = 1'b0;
            endcase
        end else if (i_cmd.wr_second && r_status == ST_OK
                     && r_item.operation == OP_TRADE) begin
            w_en = 1'b1; w_addr = r_b_idx; w_data = w_b_new;
        end
    end

    // status is final once lookup ends; latch it as WR0 is entered
    always_ff @(posedge i_clk) begin
        if (o_sts.scan_done && i_cmd.mode == SCAN_LOOKUP) r_status <= w_status;
    end

    // ---------------- top-N level lists, one per side ----------------
    logic [31:0] r_lp  [2][LEVELS_SHOWN];
    logic [31:0] r_lv  [2][LEVELS_SHOWN];
    logic        r_lok [2][LEVELS_SHOWN];
    logic [31:0] n_lp  [LEVELS_SHOWN];
    logic [31:0] n_lv  [LEVELS_SHOWN];
    logic        n_lok [LEVELS_SHOWN];
    logic        w_gt  [LEVELS_SHOWN];
    logic        w_eq  [LEVELS_SHOWN];
    logic        w_any_eq;
    logic [32:0] w_sum [LEVELS_SHOWN];
    logic        w_s;
    logic [31:0] w_x;
    logic [31:0] w_vol;

    assign w_s   = r_rdata.side;
    assign w_x   = r_rdata.price;
    assign w_vol = {8'd0, r_rdata.volume};

    always_comb begin
        w_any_eq = 1'b0;
        for (int k = 0; k < LEVELS_SHOWN; k++) begin
            w_eq[k] = r_lok[w_s][k] && r_lp[w_s][k] == w_x;
            w_gt[k] = r_lok[w_s][k] &&
                      (w_s ? r_lp[w_s][k] < w_x : r_lp[w_s][k] > w_x);
            w_sum[k] = {1'b0, r_lv[w_s][k]} + {1'b0, w_vol};
            w_any_eq = w_any_eq | w_eq[k];
        end
        for (int k = 0; k < LEVELS_SHOWN; k++) begin
            n_lp[k]  = r_lp[w_s][k];
            n_lv[k]  = r_lv[w_s][k];
            n_lok[k] = r_lok[w_s][k];
            if (w_any_eq) begin
                if (w_eq[k]) n_lv[k] = w_sum[k][32] ? VOLUME_SAT : w_sum[k][31:0];
            end else if (!w_gt[k]) begin
                if (k == 0 || w_gt[(k == 0) ? 0 : k - 1]) begin
                    n_lp[k]  = w_x;
                    n_lv[k]  = w_vol;
                    n_lok[k] = 1'b1;
                end else begin
                    n_lp[k]  = r_lp[w_s][(k == 0) ? 0 : k - 1];
                    n_lv[k]  = r_lv[w_s][(k == 0) ? 0 : k - 1];
                    n_lok[k] = r_lok[w_s][(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.wr_first) begin
            for (int s = 0; s < 2; s++)
                for (int k = 0; k < LEVELS_SHOWN; k++) r_lok[s][k] <= 1'b0;
        end else if (r_rv && i_cmd.mode == SCAN_LEVELS && r_rdata.valid) begin
            for (int k = 0; k < LEVELS_SHOWN; k++) begin
                r_lok[w_s][k] <= n_lok[k];
                r_lp[w_s][k]  <= n_lp[k];
                r_lv[w_s][k]  <= n_lv[k];
            end
        end
    end

    // ---------------- result register ----------------
    logic          r_ovalid, r_oside;
    logic [LW-1:0] r_olvl;
    t_out_item     r_out;
    logic          n_oside;
    logic [LW-1:0] n_olvl;
    t_out_item     w_item;
    logic          w_out_xfer;

    assign w_out_xfer      = r_ovalid && o_out.ready;
    assign o_out.valid     = r_ovalid;
    assign o_out.payload   = r_out;
    assign o_sts.emit_done = w_out_xfer && r_out.last;

    always_comb begin
        if (i_cmd.emit_start) begin
            n_oside = 1'b0;
            n_olvl  = '0;
        end else if (r_olvl == LVL_LAST) begin
            n_oside = 1'b1;
            n_olvl  = '0;
        end else begin
            n_oside = r_oside;
            n_olvl  = r_olvl + 1'b1;
        end
        w_item.book_side    = n_oside;
        w_item.level        = 3'(32'(n_olvl) + 32'd1);
        w_item.level_valid  = r_lok[n_oside][n_olvl];
        w_item.level_price  = r_lok[n_oside][n_olvl] ? r_lp[n_oside][n_olvl] : 32'd0;
        w_item.level_volume = r_lok[n_oside][n_olvl] ? r_lv[n_oside][n_olvl] : 32'd0;
        w_item.status       = r_status;
        w_item.last         = n_oside && n_olvl == LVL_LAST;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_oside  <= 1'b0;
            r_olvl   <= '0;
        end else if (i_cmd.emit_start || (w_out_xfer && !r_out.last)) begin
            r_ovalid <= 1'b1;
            r_oside  <= n_oside;
            r_olvl   <= n_olvl;
        end else if (w_out_xfer) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start || w_out_xfer) r_out <= w_item;
    end

    // ---------------- checks ----------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_END)
        else $error("scan counter past table end");

    a_no_wr_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.run && w_read_mode) |-> !w_en)
        else $error("table write during read scan");

    a_buy_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LEVELS_SHOWN > 1 && r_lok[0][0] && r_lok[0][LEVELS_SHOWN > 1 ? 1 : 0])
            |-> r_lp[0][0] > r_lp[0][LEVELS_SHOWN > 1 ? 1 : 0])
        else $error("buy levels out of order");

    a_sell_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LEVELS_SHOWN > 1 && r_lok[1][0] && r_lok[1][LEVELS_SHOWN > 1 ? 1 : 0])
            |-> r_lp[1][0] < r_lp[1][LEVELS_SHOWN > 1 ? 1 : 0])
        else $error("sell levels out of order");

endmodule
`default_nettype wire

### rtl/limit_order_book_top_five.sv
`default_nettype none
// -----------------------------------------------------------------------------
// limit_order_book_top_five
// Two-sided order book reporting the best price levels of each side.
// -----------------------------------------------------------------------------
// Usage:
//   i_in carries one add, trade or cancel per transfer (valid/ready).
//   o_out carries 2*LEVELS_SHOWN results per item: buy levels 1..N, then
//   sell levels 1..N; the final one has last set. Status repeats on each.
//   Items are handled one at a time: ready is high only while idle.
//   Per item: an accept, an id lookup scan over the order table, the table
//   writes (states WR0 then WR1), a level scan over the table, then the
//   results drain at one per cycle while the receiver is ready; both scans
//   walk the single order table read port.
//   After reset a clearing pass empties the table; no item is accepted
//   until it ends.
//   A receiver stall holds the current result and the drain waits; the
//   next item is taken only after the last result transfers.
// -----------------------------------------------------------------------------
module limit_order_book_top_five #(
    parameter int BOOK_DEPTH   = lob_pkg::BOOK_DEPTH_DEF,
    parameter int LEVELS_SHOWN = lob_pkg::LEVELS_SHOWN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lob_in_if.sink    i_in,
    lob_out_if.source o_out
);
    import lob_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    lob_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    lob_datapath #(
        .BOOK_DEPTH   (BOOK_DEPTH),
        .LEVELS_SHOWN (LEVELS_SHOWN)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule
`default_nettype wire
